FILE: rtl/core/mtes_pkg.sv
// Shared types, codes and sizes for the multi-timer expiry scheduler.
`timescale 1ns / 1ps

package mtes_pkg;

    localparam int TIMER_COUNT_DEF = 8;
    localparam int CMD_DEPTH_DEF   = 2;
    localparam int RES_DEPTH_DEF   = 4;

    // Request codes on the input word
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_STOP  = 2'd1;
    localparam logic [1:0] REQ_RUN   = 2'd2;

    typedef enum logic [1:0] {
        ST_UNUSED    = 2'd0,
        ST_STOPPED   = 2'd1,
        ST_RUNNING   = 2'd2,
        ST_COMPLETED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_RUN   = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd_kind;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_SUM  = 2'd2
    } t_state;

    // Decoded command handed from front to back
    typedef struct packed {
        t_cmd_kind   kind;
        logic [2:0]  id;
        logic [15:0] param;
        logic [31:0] deadline;
        logic [31:0] now;
    } t_cmd;

    // One result word
    typedef struct packed {
        logic        fired;
        logic [2:0]  fired_id;
        logic [15:0] fired_param;
        logic [30:0] next_due_ms;
        logic        error;
        logic [15:0] status_vector;
        logic        last;
    } t_result;

endpackage

FILE: rtl/core/multi_timer_expiry_scheduler_top.sv
// Top level of the multi-timer expiry scheduler: front, queues and back end.
`timescale 1ns / 1ps
// Path: a start, stop or unknown request goes through the command queue, and its one
//   result word through the result queue; a run pushes a word for each expired timer
//   in index order, then its summary. A full result queue stalls all of these.
// Start and stop are done in idle; a run holds the back end, taking no command, through
//   dispatch, a scan of one table entry per cycle while the result queue has room, and the summary.
// Reset (i_rst_n low, synchronous): queues empty, scanner idle, all timers unused.

module multi_timer_expiry_scheduler_top
    import mtes_pkg::*;
#(
    parameter int TIMER_COUNT = TIMER_COUNT_DEF,
    parameter int CMD_DEPTH   = CMD_DEPTH_DEF,
    parameter int RES_DEPTH   = RES_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: enable mask
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    // request side
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_req_type,
    input  logic [2:0]  i_timer_id,
    input  logic [15:0] i_timer_param,
    input  logic [31:0] i_duration_ms,
    input  logic [31:0] i_now_ms,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic        o_fired,
    output logic [2:0]  o_fired_id,
    output logic [15:0] o_fired_param,
    output logic [30:0] o_next_due_ms,
    output logic        o_error,
    output logic [15:0] o_status_vector,
    output logic        o_last
);

    t_cmd    w_cmd_in, w_cmd_out;
    logic    w_cmd_push, w_cmd_empty, w_cmd_pop;
    t_result w_res_in, w_res_out;
    logic    w_res_push, w_res_full;

    // Front end: decode the word and add the duration to now.
    mtes_front u_front (
        .i_push        (push),
        .i_q_full      (full),
        .i_req_type    (i_req_type),
        .i_timer_id    (i_timer_id),
        .i_timer_param (i_timer_param),
        .i_duration_ms (i_duration_ms),
        .i_now_ms      (i_now_ms),
        .o_q_push      (w_cmd_push),
        .o_cmd         (w_cmd_in)
    );

    // Command queue decouples request acceptance from a long scan.
    mtes_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .o_full  (full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    // Back end: owns the timer table; scans one timer per cycle on a run while the result queue has room.
    mtes_back #(
        .TIMER_COUNT (TIMER_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (!w_cmd_empty),
        .i_cmd       (w_cmd_out),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    // Result queue; the back end stalls when it fills.
    mtes_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    assign o_fired         = w_res_out.fired;
    assign o_fired_id      = w_res_out.fired_id;
    assign o_fired_param   = w_res_out.fired_param;
    assign o_next_due_ms   = w_res_out.next_due_ms;
    assign o_error         = w_res_out.error;
    assign o_status_vector = w_res_out.status_vector;
    assign o_last          = w_res_out.last;

endmodule

FILE: rtl/core/mtes_fifo.sv
// Generic first-word-fall-through queue used between the stages.
`timescale 1ns / 1ps

module mtes_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AddrW:0]   r_wr_ptr, n_wr_ptr;
    logic [AddrW:0]   r_rd_ptr, n_rd_ptr;
    logic             w_wr_en, w_rd_en;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[AddrW] != r_rd_ptr[AddrW]) &&
                     (r_wr_ptr[AddrW-1:0] == r_rd_ptr[AddrW-1:0]);
    assign w_wr_en = i_push && !o_full;
    assign w_rd_en = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr[AddrW-1:0]];

    always_comb begin
        n_wr_ptr = w_wr_en ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_rd_en ? r_rd_ptr + 1'b1 : r_rd_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr_ptr[AddrW-1:0]] <= i_data;
        end
    end

endmodule

FILE: rtl/core/mtes_front.sv
// Front end: decodes requests and precomputes start deadlines.
`timescale 1ns / 1ps

module mtes_front
    import mtes_pkg::*;
(
    input  logic        i_push,
    input  logic        i_q_full,
    input  logic [1:0]  i_req_type,
    input  logic [2:0]  i_timer_id,
    input  logic [15:0] i_timer_param,
    input  logic [31:0] i_duration_ms,
    input  logic [31:0] i_now_ms,
    output logic        o_q_push,
    output t_cmd        o_cmd
);

    assign o_q_push = i_push && !i_q_full;

    always_comb begin
        case (i_req_type)
            REQ_START: o_cmd.kind = CMD_START;
            REQ_STOP:  o_cmd.kind = CMD_STOP;
            REQ_RUN:   o_cmd.kind = CMD_RUN;
            default:   o_cmd.kind = CMD_NOP;
        endcase
        o_cmd.id       = i_timer_id;
        o_cmd.param    = i_timer_param;
        // wraps mod 2^32
        o_cmd.deadline = i_now_ms + i_duration_ms;
        o_cmd.now      = i_now_ms;
    end

endmodule

FILE: rtl/core/mtes_back.sv
// Back end: timer table, start/stop execution and the expiry scan.
`timescale 1ns / 1ps

module mtes_back
    import mtes_pkg::*;
#(
    parameter int TIMER_COUNT = TIMER_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    input  logic       i_res_full,
    output logic       o_res_push,
    output t_result    o_res
);

    localparam int IdxW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(TIMER_COUNT - 1);

    t_state          r_state, n_state;
    t_status         r_status [TIMER_COUNT];
    t_status         n_status [TIMER_COUNT];
    logic [15:0]     r_param  [TIMER_COUNT];
    logic [31:0]     r_deadline [TIMER_COUNT];
    logic [IdxW-1:0] r_idx, n_idx;
    logic [30:0]     r_best, n_best;
    logic            r_any, n_any;
    logic [31:0]     r_now, n_now;

    logic [IdxW-1:0] w_id_idx;
    logic            w_id_ok;
    logic            w_err;
    logic            w_wr_start;
    logic [31:0]     w_diff;
    logic            w_expired;
    logic [2*TIMER_COUNT-1:0] w_vec;

    assign w_id_idx  = i_cmd.id[IdxW-1:0];
    assign w_id_ok   = (32'(i_cmd.id) < 32'(TIMER_COUNT)) &&
                       (r_status[w_id_idx] != ST_UNUSED);
    assign w_diff    = r_deadline[r_idx] - r_now;
    assign w_expired = (w_diff == 32'd0) || w_diff[31];

    for (genvar g = 0; g < TIMER_COUNT; g++) begin : g_pack
        assign w_vec[2*g +: 2] = n_status[g];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && !i_res_full && i_cmd.kind == CMD_RUN) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_res_full && r_idx == LastIdx) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (!i_res_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control and table updates
    always_comb begin
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        w_err      = 1'b0;
        w_wr_start = 1'b0;
        n_status   = r_status;
        n_idx      = r_idx;
        n_best     = r_best;
        n_any      = r_any;
        n_now      = r_now;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        CMD_START: begin
                            o_res_push = 1'b1;
                            w_err      = !w_id_ok;
                            if (w_id_ok) begin
                                n_status[w_id_idx] = ST_RUNNING;
                                w_wr_start         = 1'b1;
                            end
                        end
                        CMD_STOP: begin
                            o_res_push = 1'b1;
                            w_err      = !w_id_ok;
                            if (w_id_ok) begin
                                n_status[w_id_idx] = ST_STOPPED;
                            end
                        end
                        CMD_RUN: begin
                            n_idx  = '0;
                            n_best = '1;
                            n_any  = 1'b0;
                            n_now  = i_cmd.now;
                        end
                        default: begin
                            o_res_push = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!i_res_full) begin
                    n_idx = r_idx + 1'b1;
                    if (r_status[r_idx] == ST_RUNNING) begin
                        if (w_expired) begin
                            n_status[r_idx] = ST_COMPLETED;
                            o_res_push      = 1'b1;
                        end else if (!r_any || w_diff[30:0] < r_best) begin
                            n_best = w_diff[30:0];
                            n_any  = 1'b1;
                        end
                    end
                end
            end
            S_SUM: begin
                o_res_push = !i_res_full;
            end
            default: ;
        endcase
    end

    // result word
    always_comb begin
        o_res               = '0;
        o_res.fired         = (r_state == S_SCAN);
        o_res.error         = w_err;
        o_res.status_vector = 16'(w_vec);
        o_res.last          = (r_state != S_SCAN);
        if (r_state == S_SCAN) begin
            o_res.fired_id    = 3'(r_idx);
            o_res.fired_param = r_param[r_idx];
        end
        if (r_state == S_SUM && r_any) begin
            o_res.next_due_ms = r_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_any   <= 1'b0;
            for (int i = 0; i < TIMER_COUNT; i++) begin
                r_status[i] <= ST_UNUSED;
            end
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_any   <= n_any;
            for (int i = 0; i < TIMER_COUNT; i++) begin
                if (i_cfg_we) begin
                    r_status[i] <= i_cfg_data[i] ? ST_STOPPED : ST_UNUSED;
                end else begin
                    r_status[i] <= n_status[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= n_best;
        r_now  <= n_now;
        if (w_wr_start) begin
            r_param[w_id_idx]    <= i_cmd.param;
            r_deadline[w_id_idx] <= i_cmd.deadline;
        end
    end

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into a full queue");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == S_IDLE && i_cmd_valid))
        else $error("command popped outside idle");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (32'(r_idx) < 32'(TIMER_COUNT)))
        else $error("scan index beyond table");

    a_sum_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM && o_res_push) |=> (r_state == S_IDLE))
        else $error("summary did not end the run");

endmodule

FILE: tb/tb_multi_timer_expiry_scheduler_top.sv
// Self-checking testbench for the multi-timer expiry scheduler top level.
`timescale 1ns / 1ps

module tb_multi_timer_expiry_scheduler_top;
    import mtes_pkg::*;

    localparam int          NUM_TIMERS  = TIMER_COUNT_DEF;
    localparam logic [1:0]  REQ_UNKNOWN = 2'd3;     // code the block decodes as a no-op
    localparam logic [31:0] HALF_RANGE  = 32'h7FFF_FFFF;
    localparam int          IDLE_PCT    = 7;
    localparam int          CHUNK_LEN   = 32;
    localparam int          NUM_CHUNKS  = 8;
    localparam int          TAIL_CYCLES = 20;
    localparam int          CYCLE_LIMIT = 400000;

    // One request word as the sender holds it
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  id;
        logic [15:0] param;
        logic [31:0] dur;
        logic [31:0] now;
    } t_req_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_data = 8'h00;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_req_type = 2'd0;
    logic [2:0]  i_timer_id = 3'd0;
    logic [15:0] i_timer_param = 16'h0000;
    logic [31:0] i_duration_ms = 32'h0;
    logic [31:0] i_now_ms = 32'h0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_fired;
    logic [2:0]  o_fired_id;
    logic [15:0] o_fired_param;
    logic [30:0] o_next_due_ms;
    logic        o_error;
    logic [15:0] o_status_vector;
    logic        o_last;

    multi_timer_expiry_scheduler_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_req_type     (i_req_type),
        .i_timer_id     (i_timer_id),
        .i_timer_param  (i_timer_param),
        .i_duration_ms  (i_duration_ms),
        .i_now_ms       (i_now_ms),
        .empty          (empty),
        .pop            (pop),
        .o_fired        (o_fired),
        .o_fired_id     (o_fired_id),
        .o_fired_param  (o_fired_param),
        .o_next_due_ms  (o_next_due_ms),
        .o_error        (o_error),
        .o_status_vector(o_status_vector),
        .o_last         (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Shadow of the timer table, kept in step with every accepted word
    t_status     tm_state [NUM_TIMERS];
    logic [15:0] tm_param [NUM_TIMERS];
    logic [31:0] tm_due   [NUM_TIMERS];

    t_req_word   req_q [$];        // words waiting for the sender
    t_result     timer_word_q [$]; // result words the table is due to emit, oldest first
    t_req_word   cur_req;          // word currently on the request ports
    int unsigned reqs_left = 0;    // queued but not yet taken by the block
    int unsigned mism_count = 0;
    int unsigned cycles = 0;
    bit          calm = 1'b0;      // suppresses random idling on both sides
    logic [31:0] virt_now = 32'h0; // running uptime for well-formed random traffic

    function automatic logic [15:0] pack_states();
        logic [15:0] v;
        v = '0;
        for (int i = 0; i < NUM_TIMERS; i++) v[2*i +: 2] = tm_state[i];
        return v;
    endfunction

    task automatic apply_mask(input logic [7:0] m);
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (m[i]) tm_state[i] = ST_STOPPED;
            else      tm_state[i] = ST_UNUSED;
        end
    endtask

    // Advance the shadow table by one request and queue the words it causes
    task automatic step_timer_table(input t_req_word rq);
        t_result     w;
        logic [31:0] gap;
        logic [31:0] soonest;
        logic        live;
        w = '0;
        case (rq.kind)
            REQ_START, REQ_STOP: begin
                if (tm_state[rq.id] != ST_UNUSED) begin
                    if (rq.kind == REQ_START) begin
                        tm_param[rq.id] = rq.param;
                        tm_due[rq.id]   = rq.now + rq.dur;
                        tm_state[rq.id] = ST_RUNNING;
                    end else begin
                        tm_state[rq.id] = ST_STOPPED;
                    end
                end else begin
                    w.error = 1'b1;
                end
                w.status_vector = pack_states();
                w.last = 1'b1;
                timer_word_q.push_back(w);
            end
            REQ_RUN: begin
                soonest = '1;
                live = 1'b0;
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (tm_state[i] == ST_RUNNING) begin
                        gap = tm_due[i] - rq.now;
                        // zero or top bit set: deadline reached, wrap-aware
                        if (gap == 32'h0 || gap > HALF_RANGE) begin
                            tm_state[i] = ST_COMPLETED;
                            w = '0;
                            w.fired = 1'b1;
                            w.fired_id = 3'(i);
                            w.fired_param = tm_param[i];
                            w.status_vector = pack_states();
                            timer_word_q.push_back(w);
                        end else if (gap < soonest) begin
                            soonest = gap;
                            live = 1'b1;
                        end
                    end
                end
                w = '0;
                w.next_due_ms = live ? soonest[30:0] : 31'h0;
                w.status_vector = pack_states();
                w.last = 1'b1;
                timer_word_q.push_back(w);
            end
            default: begin
                w.status_vector = pack_states();
                w.last = 1'b1;
                timer_word_q.push_back(w);
            end
        endcase
    endtask

    task automatic report(input string msg);
        $display("tb: mismatch at cycle %0d: %s", cycles, msg);
        mism_count++;
    endtask

    task automatic cmp_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
        if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Sender: holds a word until the block takes it, then maybe idles
    always @(posedge i_clk) begin : tx_side
        t_req_word nxt;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                step_timer_table(cur_req);
                reqs_left--;
            end
            if (!push || !full) begin
                if (req_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    nxt = req_q.pop_front();
                    cur_req = nxt;
                    i_req_type    <= nxt.kind;
                    i_timer_id    <= nxt.id;
                    i_timer_param <= nxt.param;
                    i_duration_ms <= nxt.dur;
                    i_now_ms      <= nxt.now;
                    push <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Receiver: random pop stalls, every taken word checked against the oldest prediction
    always @(posedge i_clk) begin : rx_side
        t_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (timer_word_q.size() == 0) begin
                    report("result word with nothing pending");
                end else begin
                    want = timer_word_q.pop_front();
                    cmp_field("fired", 32'(o_fired), 32'(want.fired));
                    cmp_field("fired_id", 32'(o_fired_id), 32'(want.fired_id));
                    cmp_field("fired_param", 32'(o_fired_param), 32'(want.fired_param));
                    cmp_field("next_due_ms", 32'(o_next_due_ms), 32'(want.next_due_ms));
                    cmp_field("error", 32'(o_error), 32'(want.error));
                    cmp_field("status_vector", 32'(o_status_vector),
                              32'(want.status_vector));
                    cmp_field("last", 32'(o_last), 32'(want.last));
                end
            end
            pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic add_req(input logic [1:0] k, input logic [2:0] id, input logic [15:0] p,
                           input logic [31:0] d, input logic [31:0] n);
        t_req_word rq;
        rq = '{kind: k, id: id, param: p, dur: d, now: n};
        req_q.push_back(rq);
        reqs_left++;
    endtask

    // Wait until every queued word is taken and every predicted word has come back
    task automatic drain();
        while (reqs_left != 0 || timer_word_q.size() != 0) @(posedge i_clk);
    endtask

    // Mask writes only happen with the block drained
    task automatic write_mask(input logic [7:0] m);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        apply_mask(m);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly well-formed traffic against a moving uptime: starts with short delays,
    // stops, and scans as time moves on; a little noise with arbitrary fields.
    task automatic queue_random(input int count);
        int          r;
        logic [1:0]  k;
        logic [2:0]  id;
        logic [15:0] p;
        logic [31:0] d;
        logic [31:0] n;
        for (int j = 0; j < count; j++) begin
            r = $urandom_range(0, 99);
            if (r < 3)      virt_now = $urandom;
            else if (r < 6) virt_now = 32'hFFFF_FF00 + $urandom_range(0, 255);
            id = 3'($urandom_range(0, 7));
            p  = 16'($urandom);
            d  = $urandom;
            n  = virt_now;
            r  = $urandom_range(0, 99);
            if (r < 40) begin
                k = REQ_START;
                case ($urandom_range(0, 9))
                    6:       d = $urandom;
                    7:       d = HALF_RANGE - 1 + $urandom_range(0, 2);
                    8:       d = 32'h0;
                    9:       d = 32'hFFFF_FFFF - $urandom_range(0, 3);
                    default: d = $urandom_range(0, 300);
                endcase
            end else if (r < 55) begin
                k = REQ_STOP;
            end else if (r < 92) begin
                k = REQ_RUN;
                virt_now = virt_now + $urandom_range(0, 120);
                n = virt_now;
            end else if (r < 96) begin
                k = REQ_UNKNOWN;
            end else begin
                k = 2'($urandom_range(0, 3));
                n = $urandom;
            end
            add_req(k, id, p, d, n);
        end
    endtask

    initial begin : main_seq
        for (int i = 0; i < NUM_TIMERS; i++) begin
            tm_state[i] = ST_UNUSED;
            tm_param[i] = '0;
            tm_due[i]   = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: all timers configured, every one started so that it is due by a run at the wrap edge
        write_mask(8'hFF);
        add_req(REQ_RUN,   3'd0, 16'h0000, 32'h0000_0000, 32'h0000_0000); // nothing running
        add_req(REQ_START, 3'd0, 16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        add_req(REQ_START, 3'd1, 16'h0000, 32'hFFFF_FFFF, 32'h0000_0000);
        add_req(REQ_START, 3'd2, 16'h8001, 32'h8000_0000, 32'h7FFF_FFFF);
        add_req(REQ_START, 3'd3, 16'h1234, 32'h7FFF_FFFF, 32'h0000_0000);
        add_req(REQ_START, 3'd4, 16'hAAAA, 32'h0000_0000, 32'h8000_0000);
        add_req(REQ_START, 3'd5, 16'h00FF, 32'h0000_0001, 32'hFFFF_FFFE);
        add_req(REQ_START, 3'd6, 16'hFF00, 32'h3FFF_FFFF, 32'h4000_0000);
        add_req(REQ_START, 3'd7, 16'h7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(REQ_RUN,   3'd0, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF); // all eight fire
        // Remaining time one short of half the range is not yet due; deadline across the wrap
        add_req(REQ_START, 3'd0, 16'h0F0F, 32'h7FFF_FFFF, 32'h0000_0000);
        add_req(REQ_START, 3'd1, 16'hF0F0, 32'h0000_0014, 32'hFFFF_FFF0);
        add_req(REQ_START, 3'd2, 16'h5A5A, 32'h0000_0005, 32'h0000_0000);
        add_req(REQ_STOP,  3'd2, 16'h0000, 32'h0000_0000, 32'h0000_0000);
        add_req(REQ_UNKNOWN, 3'd7, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(REQ_RUN,   3'd0, 16'h0000, 32'h0000_0000, 32'h0000_0000);
        add_req(REQ_RUN,   3'd0, 16'h0000, 32'h0000_0000, 32'h0000_0004); // exact deadline
        add_req(REQ_STOP,  3'd3, 16'h0000, 32'h0000_0000, 32'h0000_0004); // completed to stopped
        drain();

        // Directed: sparse mask, unused timers flag an error and stay put
        write_mask(8'h81);
        add_req(REQ_START, 3'd3, 16'hBEEF, 32'h0000_0010, 32'h0000_0064);
        add_req(REQ_STOP,  3'd4, 16'h0000, 32'h0000_0000, 32'h0000_0064);
        add_req(REQ_START, 3'd7, 16'hC0DE, 32'h0000_0000, 32'h0000_0064);
        add_req(REQ_START, 3'd0, 16'h0001, 32'h0000_0002, 32'h0000_0064);
        add_req(REQ_RUN,   3'd0, 16'h0000, 32'h0000_0000, 32'h0000_0065);
        add_req(REQ_RUN,   3'd0, 16'h0000, 32'h0000_0000, 32'h8000_0066); // top bit set
        drain();

        // Random chunks; each boundary drains the block, some rewrite the mask
        for (int c = 0; c < NUM_CHUNKS; c++) begin
            case (c)
                0:       write_mask(8'hFF);
                2, 6:    ;                      // pause only, no mask change
                3:       write_mask(8'h00);
                4:       write_mask(8'hFF);
                default: write_mask(8'($urandom_range(0, 255)));
            endcase
            calm = (c == 4);                    // one long run with no idling on either side
            queue_random(CHUNK_LEN);
            drain();
            calm = 1'b0;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mism_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
